FILE: rtl/crcfr_pkg.sv
// ----------------------------------------------------------------------------
// crcfr_pkg
// Shared constants, codes and the byte-wide CRC16 update for the framed
// serial receiver with its cached status record.
// ----------------------------------------------------------------------------
`default_nettype none

package crcfr_pkg;

  // frame result codes
  typedef enum logic [1:0] {
    ST_CRC_GOOD = 2'd0,
    ST_CRC_BAD  = 2'd1,
    ST_OVERSIZE = 2'd2
  } frame_status_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_STATUS_COMMAND = 1'b0,
    REG_VEHICLE_DEVICE = 1'b1
  } cfg_reg_t;

  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [7:0]  SYNC_FIRST     = 8'hAA;
  localparam logic [7:0]  SYNC_SECOND    = 8'h55;
  localparam logic [7:0]  STATUS_CMD_RST = 8'h0A;
  localparam logic [7:0]  VEHICLE_RST    = 8'h01;
  localparam int          STATUS_BYTES   = 5;
  localparam logic [7:0]  STATUS_MIN_LEN = 8'd7;

  // MODBUS CRC16, reflected, one byte at a time
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/crc16_frame_receiver_status_cache.sv
// A frame's last byte passes the input register and then the result register on its way to the output.
// Throughput: one byte per cycle while no result waits at the output; the per-byte
// CRC update and framing decode sit between the input register and the result register.
// A frame result waiting at the output stalls the byte pipeline behind it.
// Reset (rst, synchronous): hunting for sync, CRC seed 0xFFFF, cache cleared,
// registers back to status command 0x0A and vehicle device 0x01.
// ----------------------------------------------------------------------------
// crc16_frame_receiver_status_cache
// Sync hunt (AA 55), LEN, content and CRC16 check of framed serial bytes; good
// status frames update a cached status record reported with each frame item.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_frame_receiver_status_cache #(
  parameter int MAX_FRAME_BYTES = 70
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // configuration
  input  wire logic                         cfg_we,
  input  wire crcfr_pkg::cfg_reg_t          cfg_index,
  input  wire logic [7:0]                   cfg_data,
  // byte input
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [7:0]                   rx_byte,
  // frame results
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [1:0]                        frame_status,
  output logic [7:0]                        frame_device,
  output logic [7:0]                        frame_command,
  output logic [7:0]                        frame_length,
  output logic                              status_updated,
  output logic                              cached_valid,
  output logic [7:0]                        cached_device,
  output logic [7:0]                        cached_state,
  output logic [7:0]                        cached_speed,
  output logic [7:0]                        cached_grip,
  output logic [15:0]                       cached_param,
  output logic [7:0]                        cached_flag
);

  import crcfr_pkg::*;

  localparam int PW    = $clog2(MAX_FRAME_BYTES);
  localparam int CMP_W = ((PW > 9) ? PW : 9) + 1;

  // configuration registers
  logic [7:0] status_command;
  logic [7:0] vehicle_device;

  always_ff @(posedge clk) begin
    if (rst) begin
      status_command <= STATUS_CMD_RST;
      vehicle_device <= VEHICLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STATUS_COMMAND: status_command <= cfg_data;
        REG_VEHICLE_DEVICE: vehicle_device <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  logic       in_full;
  logic [7:0] rx_q;
  logic       advance;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rx_q <= rx_byte;
    end
  end

  // frame state
  logic [PW-1:0] byte_position, byte_position_next;
  logic [7:0]    content_length, content_length_next;
  logic [15:0]   running_crc, running_crc_next;
  logic [7:0]    crc_low_received, crc_low_received_next;
  logic [7:0]    header_device, header_device_next;
  logic [7:0]    header_command, header_command_next;
  logic [7:0]    status_bytes [STATUS_BYTES];

  logic        cache_valid_bit;
  logic [7:0]  cache_device_id, cache_state_byte, cache_speed_byte, cache_grip_byte;
  logic [15:0] cache_param_word;
  logic [7:0]  cache_flag_byte;

  // per-byte decode
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] len_ext;
  logic             emit;
  logic             cache_write;
  logic [1:0]       res_status;
  logic [7:0]       res_device, res_command, res_length;
  logic [7:0]       cmd_eff;
  logic             crc_good;

  assign pos_ext = CMP_W'(byte_position);
  assign len_ext = CMP_W'(content_length);
  assign cmd_eff = (pos_ext == CMP_W'(4)) ? rx_q : header_command;
  assign crc_good = ({rx_q, crc_low_received} == running_crc);

  always_comb begin
    byte_position_next    = byte_position;
    content_length_next   = content_length;
    running_crc_next      = running_crc;
    crc_low_received_next = crc_low_received;
    header_device_next    = header_device;
    header_command_next   = header_command;
    emit        = 1'b0;
    cache_write = 1'b0;
    res_status  = ST_CRC_GOOD;
    res_device  = header_device;
    res_command = cmd_eff;
    res_length  = content_length;

    if (pos_ext == CMP_W'(0)) begin
      if (rx_q == SYNC_FIRST) begin
        byte_position_next = PW'(1);
      end
    end else if (pos_ext == CMP_W'(1)) begin
      // a bad second sync byte is dropped, even if it is AA
      byte_position_next = (rx_q == SYNC_SECOND) ? PW'(2) : PW'(0);
    end else if (pos_ext == CMP_W'(2)) begin
      content_length_next = rx_q;
      res_length          = rx_q;
      if (CMP_W'(rx_q) + CMP_W'(5) > CMP_W'(MAX_FRAME_BYTES)) begin
        byte_position_next = PW'(0);
        running_crc_next   = CRC_INIT;
        emit        = 1'b1;
        res_status  = ST_OVERSIZE;
        res_device  = 8'h00;
        res_command = 8'h00;
      end else begin
        byte_position_next = PW'(3);
        running_crc_next   = crc16_byte(CRC_INIT, rx_q);
      end
    end else begin
      if (pos_ext == CMP_W'(3)) header_device_next = rx_q;
      if (pos_ext == CMP_W'(4)) header_command_next = rx_q;
      byte_position_next = byte_position + PW'(1);
      if (pos_ext <= len_ext + CMP_W'(2)) begin
        running_crc_next = crc16_byte(running_crc, rx_q);
      end else if (pos_ext == len_ext + CMP_W'(3)) begin
        crc_low_received_next = rx_q;
      end else begin
        byte_position_next = PW'(0);
        running_crc_next   = CRC_INIT;
        emit        = 1'b1;
        res_status  = crc_good ? ST_CRC_GOOD : ST_CRC_BAD;
        cache_write = crc_good && (cmd_eff == status_command) &&
                      (content_length >= STATUS_MIN_LEN);
      end
    end
  end

  logic step;
  assign step = in_full && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      content_length   <= '0;
      running_crc      <= CRC_INIT;
      crc_low_received <= '0;
      header_device    <= '0;
      header_command   <= '0;
    end else if (step) begin
      byte_position    <= byte_position_next;
      content_length   <= content_length_next;
      running_crc      <= running_crc_next;
      crc_low_received <= crc_low_received_next;
      header_device    <= header_device_next;
      header_command   <= header_command_next;
    end
  end

  // status record bytes, frame offsets 5..9
  always_ff @(posedge clk) begin
    for (int i = 0; i < STATUS_BYTES; i++) begin
      if (step && pos_ext == CMP_W'(5 + i)) begin
        status_bytes[i] <= rx_q;
      end
    end
  end

  // cached status record
  always_ff @(posedge clk) begin
    if (rst) begin
      cache_valid_bit  <= 1'b0;
      cache_device_id  <= '0;
      cache_state_byte <= '0;
      cache_speed_byte <= '0;
      cache_grip_byte  <= '0;
      cache_param_word <= '0;
      cache_flag_byte  <= '0;
    end else if (step && cache_write) begin
      cache_valid_bit  <= 1'b1;
      cache_device_id  <= header_device;
      cache_state_byte <= status_bytes[0];
      if (header_device == vehicle_device) begin
        cache_speed_byte <= status_bytes[1];
        cache_grip_byte  <= 8'h00;
      end else begin
        cache_speed_byte <= 8'h00;
        cache_grip_byte  <= status_bytes[1];
      end
      cache_param_word <= {status_bytes[3], status_bytes[2]};
      cache_flag_byte  <= status_bytes[4];
    end
  end

  // result register; cache only moves when a result is loaded, so it is
  // presented directly
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      frame_status   <= res_status;
      frame_device   <= res_device;
      frame_command  <= res_command;
      frame_length   <= res_length;
      status_updated <= cache_write;
    end
  end

  assign cached_valid  = cache_valid_bit;
  assign cached_device = cache_device_id;
  assign cached_state  = cache_state_byte;
  assign cached_speed  = cache_speed_byte;
  assign cached_grip   = cache_grip_byte;
  assign cached_param  = cache_param_word;
  assign cached_flag   = cache_flag_byte;

endmodule

`default_nettype wire

FILE: rtl/crcfr_checker.sv
// ----------------------------------------------------------------------------
// crcfr_checker
// Port-level checks on frame result items of the framed serial receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  frame_status,
  input wire logic [7:0]  frame_device,
  input wire logic [7:0]  frame_command,
  input wire logic        status_updated,
  input wire logic        cached_valid,
  input wire logic [7:0]  cached_device
);

  import crcfr_pkg::*;

  // a stalled item holds its status
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_status))
    else $error("result item changed while stalled");

  // no item in the cycle after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result item right after reset");

  // a cache update only comes from a good frame and leaves the cache valid
  a_update: assert property (@(posedge clk) disable iff (rst)
    out_valid && status_updated |->
      frame_status == ST_CRC_GOOD && cached_valid && cached_device == frame_device)
    else $error("cache update inconsistent with frame");

  // oversize frames carry no header and never update
  a_oversize: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_status == ST_OVERSIZE |->
      frame_device == 8'h00 && frame_command == 8'h00 && !status_updated)
    else $error("oversize item carries header or update");

endmodule

bind crc16_frame_receiver_status_cache crcfr_checker u_crcfr_checker (.*);

`default_nettype wire

FILE: tb/crc16_frame_receiver_status_cache_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc16_frame_receiver_status_cache_test
// Feeds framed serial bytes (sync hunt, LEN, content, CRC16) through the
// receiver and checks every frame item against a local model of the framing,
// the CRC and the cached status record, across several register settings.
// ----------------------------------------------------------------------------
module crc16_frame_receiver_status_cache_test;
  import crcfr_pkg::*;

  localparam int FRAME_LIMIT = 70;
  localparam int RUN_LIMIT   = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BYTES = 100;
  localparam int SETTLE      = 6;
  localparam int PHASES      = 4;

  typedef enum logic [1:0] {
    FK_FRAME,
    FK_BAD_CRC,
    FK_BAD_SYNC
  } frame_kind_t;

  typedef struct packed {
    frame_kind_t   kind;
    logic [7:0]    len;
    logic [7:0]    dev;
    logic [7:0]    cmd;
    logic [7:0]    fill;
    logic          typed;
    frame_status_t t_status;
    logic [7:0]    t_dev;
    logic [7:0]    t_cmd;
  } frame_row_t;

  typedef struct packed {
    frame_status_t status;
    logic [7:0]    device;
    logic [7:0]    command;
    logic [7:0]    length;
    logic          updated;
    logic          cvalid;
    logic [7:0]    cdevice;
    logic [7:0]    cstate;
    logic [7:0]    cspeed;
    logic [7:0]    cgrip;
    logic [15:0]   cparam;
    logic [7:0]    cflag;
  } frame_report_t;

  // typed expectations only while the cache is still clear after reset
  frame_row_t directed_rows [14] = '{
    '{FK_FRAME,    8'hFF, 8'h00, 8'h00, 8'h00, 1'b1, ST_OVERSIZE, 8'h00, 8'h00},
    '{FK_FRAME,    8'h42, 8'h00, 8'h00, 8'h00, 1'b1, ST_OVERSIZE, 8'h00, 8'h00},
    '{FK_BAD_CRC,  8'h03, 8'h12, 8'h34, 8'hA5, 1'b1, ST_CRC_BAD,  8'h12, 8'h34},
    '{FK_FRAME,    8'h02, 8'h00, 8'hFF, 8'h00, 1'b1, ST_CRC_GOOD, 8'h00, 8'hFF},
    '{FK_BAD_SYNC, 8'h00, 8'hAA, 8'h00, 8'h00, 1'b0, ST_CRC_GOOD, 8'h00, 8'h00},
    '{FK_BAD_SYNC, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, ST_CRC_GOOD, 8'h00, 8'h00},
    '{FK_FRAME,    8'h00, 8'h00, 8'h00, 8'h00, 1'b0, ST_CRC_GOOD, 8'h00, 8'h00},
    '{FK_FRAME,    8'h01, 8'h7E, 8'h00, 8'h00, 1'b0, ST_CRC_GOOD, 8'h00, 8'h00},
    '{FK_FRAME,    8'h07, 8'h01, 8'h0A, 8'h00, 1'b0, ST_CRC_GOOD, 8'h00, 8'h00},
    '{FK_FRAME,    8'h08, 8'h02, 8'h0A, 8'hFF, 1'b0, ST_CRC_GOOD, 8'h00, 8'h00},
    '{FK_FRAME,    8'h06, 8'h01, 8'h0A, 8'h33, 1'b0, ST_CRC_GOOD, 8'h00, 8'h00},
    '{FK_BAD_CRC,  8'h07, 8'h03, 8'h0A, 8'hC3, 1'b0, ST_CRC_GOOD, 8'h00, 8'h00},
    '{FK_FRAME,    8'h41, 8'hFF, 8'h0A, 8'h5A, 1'b0, ST_CRC_GOOD, 8'h00, 8'h00},
    '{FK_FRAME,    8'h07, 8'h01, 8'h0B, 8'h96, 1'b0, ST_CRC_GOOD, 8'h00, 8'h00}
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  cfg_reg_t         cfg_index = REG_STATUS_COMMAND;
  logic [7:0]       cfg_data = 8'h00;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       rx_byte = 8'h00;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [1:0]       frame_status;
  logic [7:0]       frame_device;
  logic [7:0]       frame_command;
  logic [7:0]       frame_length;
  logic             status_updated;
  logic             cached_valid;
  logic [7:0]       cached_device;
  logic [7:0]       cached_state;
  logic [7:0]       cached_speed;
  logic [7:0]       cached_grip;
  logic [15:0]      cached_param;
  logic [7:0]       cached_flag;

  crc16_frame_receiver_status_cache #(
    .MAX_FRAME_BYTES(FRAME_LIMIT)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .frame_status(frame_status),
    .frame_device(frame_device),
    .frame_command(frame_command),
    .frame_length(frame_length),
    .status_updated(status_updated),
    .cached_valid(cached_valid),
    .cached_device(cached_device),
    .cached_state(cached_state),
    .cached_speed(cached_speed),
    .cached_grip(cached_grip),
    .cached_param(cached_param),
    .cached_flag(cached_flag)
  );

  always #5 clk = ~clk;

  // receiver model state
  logic [6:0]  rx_pos = '0;
  logic [7:0]  rx_len = '0;
  logic [15:0] rx_crc = CRC_INIT;
  logic [7:0]  rx_crc_lo = '0;
  logic [7:0]  hdr_dev = '0;
  logic [7:0]  hdr_cmd = '0;
  logic [7:0]  stat_buf [5];
  logic        c_valid = 1'b0;
  logic [7:0]  c_dev = '0;
  logic [7:0]  c_state = '0;
  logic [7:0]  c_speed = '0;
  logic [7:0]  c_grip = '0;
  logic [15:0] c_param = '0;
  logic [7:0]  c_flag = '0;
  logic [7:0]  cfg_status_cmd = STATUS_CMD_RST;
  logic [7:0]  cfg_vehicle = VEHICLE_RST;

  frame_report_t pending_frames [$];
  logic [7:0]    frame_bytes [$];
  int            mismatches = 0;
  int            send_idle_pct = 18;
  int            recv_idle_pct = 18;
  logic          long_hold_go = 1'b0;
  int            hold_count = 0;

  // bit-serial form of the reflected CRC16 update
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] acc;
    logic        fb;
    acc = crc;
    for (int i = 0; i < 8; i++) begin
      fb  = acc[0] ^ b[i];
      acc = acc >> 1;
      if (fb) acc = acc ^ CRC_POLY;
    end
    return acc;
  endfunction

  function automatic frame_report_t make_report(input frame_status_t st, input logic [7:0] dev,
                                                input logic [7:0] cmd, input logic [7:0] len,
                                                input logic upd);
    frame_report_t r;
    r.status  = st;
    r.device  = dev;
    r.command = cmd;
    r.length  = len;
    r.updated = upd;
    r.cvalid  = c_valid;
    r.cdevice = c_dev;
    r.cstate  = c_state;
    r.cspeed  = c_speed;
    r.cgrip   = c_grip;
    r.cparam  = c_param;
    r.cflag   = c_flag;
    return r;
  endfunction

  function automatic void receiver_take_byte(input logic [7:0] b, output logic produced,
                                             output frame_report_t rep);
    int          p;
    int          span;
    logic [15:0] got;
    logic        good;
    logic        upd;
    p = rx_pos;
    span = rx_len;
    produced = 1'b0;
    rep = '0;
    upd = 1'b0;
    if (p == 0) begin
      if (b == SYNC_FIRST) rx_pos = 7'd1;
      return;
    end
    if (p == 1) begin
      // a bad second sync byte is dropped, even another AA
      rx_pos = (b == SYNC_SECOND) ? 7'd2 : 7'd0;
      return;
    end
    if (p == 2) begin
      rx_len = b;
      rx_crc = crc_step(CRC_INIT, b);
      if (int'(b) + 5 > FRAME_LIMIT) begin
        rx_pos = 7'd0;
        rx_crc = CRC_INIT;
        rep = make_report(ST_OVERSIZE, 8'h00, 8'h00, b, 1'b0);
        produced = 1'b1;
        return;
      end
      rx_pos = 7'd3;
      return;
    end
    if (p == 3) hdr_dev = b;
    if (p == 4) hdr_cmd = b;
    if (p >= 5 && p <= 9) stat_buf[p - 5] = b;
    if (p <= span + 2) begin
      rx_crc = crc_step(rx_crc, b);
    end else if (p == span + 3) begin
      rx_crc_lo = b;
    end else begin
      got  = {b, rx_crc_lo};
      good = (got == rx_crc);
      if (good && hdr_cmd == cfg_status_cmd && span >= 7) begin
        c_valid = 1'b1;
        c_dev   = hdr_dev;
        c_state = stat_buf[0];
        if (hdr_dev == cfg_vehicle) begin
          c_speed = stat_buf[1];
          c_grip  = 8'h00;
        end else begin
          c_speed = 8'h00;
          c_grip  = stat_buf[1];
        end
        c_param = {stat_buf[3], stat_buf[2]};
        c_flag  = stat_buf[4];
        upd = 1'b1;
      end
      rx_pos = 7'd0;
      rx_crc = CRC_INIT;
      rep = make_report(good ? ST_CRC_GOOD : ST_CRC_BAD, hdr_dev, hdr_cmd, rx_len, upd);
      produced = 1'b1;
      return;
    end
    rx_pos = rx_pos + 7'd1;
  endfunction

  // AA 55 LEN content CRC; oversize LEN stops after the LEN byte
  function automatic void compose_frame(input logic [7:0] len, input logic [7:0] dev,
                                        input logic [7:0] cmd, input logic rand_pay,
                                        input logic [7:0] fill, input logic corrupt);
    logic [15:0] crc;
    logic [7:0]  b;
    frame_bytes = {};
    frame_bytes.push_back(SYNC_FIRST);
    frame_bytes.push_back(SYNC_SECOND);
    frame_bytes.push_back(len);
    if (int'(len) + 5 > FRAME_LIMIT) return;
    crc = crc_step(CRC_INIT, len);
    for (int i = 0; i < int'(len); i++) begin
      if (i == 0) b = dev;
      else if (i == 1) b = cmd;
      else if (rand_pay) b = 8'($urandom);
      else b = fill ^ 8'(i * 8'h1D);
      frame_bytes.push_back(b);
      crc = crc_step(crc, b);
    end
    if (corrupt) crc = crc ^ (16'h0001 << $urandom_range(15));
    frame_bytes.push_back(crc[7:0]);
    frame_bytes.push_back(crc[15:8]);
  endfunction

  function automatic logic field_matches(input string label, input logic [15:0] want,
                                         input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, label, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic use_typed,
                           input frame_report_t typed);
    logic          produced;
    frame_report_t rep;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    receiver_take_byte(b, produced, rep);
    if (produced) pending_frames.push_back(use_typed ? typed : rep);
  endtask

  task automatic send_frame_bytes(input logic use_typed, input frame_report_t typed);
    for (int i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], use_typed && (i == frame_bytes.size() - 1), typed);
  endtask

  // results can still be in the pipe from bytes that give none
  task automatic wait_for_frames_done();
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] cmd_code, input logic [7:0] dev_id);
    cfg_we    <= 1'b1;
    cfg_index <= REG_STATUS_COMMAND;
    cfg_data  <= cmd_code;
    @(posedge clk);
    cfg_status_cmd = cmd_code;
    cfg_index <= REG_VEHICLE_DEVICE;
    cfg_data  <= dev_id;
    @(posedge clk);
    cfg_vehicle = dev_id;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_chunk(inout int used);
    int         r;
    int         n;
    logic [7:0] len;
    logic [7:0] dev;
    logic [7:0] cmd;
    r = $urandom_range(99);
    if (r < 55) begin
      n = $urandom_range(99);
      if (n < 70) len = 8'($urandom_range(12, 7));
      else if (n < 85) len = 8'($urandom_range(6, 0));
      else len = 8'($urandom_range(65, 13));
      dev = $urandom_range(1) ? cfg_vehicle : 8'($urandom);
      cmd = ($urandom_range(99) < 60) ? cfg_status_cmd : 8'($urandom);
      compose_frame(len, dev, cmd, 1'b1, 8'h00, $urandom_range(99) < 12);
    end else if (r < 65) begin
      compose_frame(8'($urandom_range(255, 66)), 8'h00, 8'h00, 1'b1, 8'h00, 1'b0);
    end else if (r < 75) begin
      frame_bytes = {};
      frame_bytes.push_back(SYNC_FIRST);
      frame_bytes.push_back(($urandom_range(3) == 0) ? SYNC_FIRST : 8'($urandom));
      frame_bytes.push_back(SYNC_SECOND);
    end else if (r < 85) begin
      // cut short: the next bytes get taken as its content
      compose_frame(8'($urandom_range(20, 0)), 8'($urandom), cfg_status_cmd, 1'b1, 8'h00,
                    1'b0);
      n = $urandom_range(frame_bytes.size() - 1, 1);
      repeat (n) void'(frame_bytes.pop_back());
    end else begin
      frame_bytes = {};
      repeat ($urandom_range(4, 1)) frame_bytes.push_back(8'($urandom));
    end
    used += frame_bytes.size();
    send_frame_bytes(1'b0, '0);
  endtask

  always @(posedge clk) begin : frame_monitor
    frame_report_t want;
    logic          ok;
    if (!rst && out_valid && out_ready) begin
      if (pending_frames.size() == 0) begin
        $display("%0t: frame item arrived with none pending", $time);
        mismatches++;
      end else begin
        want = pending_frames.pop_front();
        ok = field_matches("frame_status", 16'(want.status), 16'(frame_status))
           & field_matches("frame_device", 16'(want.device), 16'(frame_device))
           & field_matches("frame_command", 16'(want.command), 16'(frame_command))
           & field_matches("frame_length", 16'(want.length), 16'(frame_length))
           & field_matches("status_updated", 16'(want.updated), 16'(status_updated))
           & field_matches("cached_valid", 16'(want.cvalid), 16'(cached_valid))
           & field_matches("cached_device", 16'(want.cdevice), 16'(cached_device))
           & field_matches("cached_state", 16'(want.cstate), 16'(cached_state))
           & field_matches("cached_speed", 16'(want.cspeed), 16'(cached_speed))
           & field_matches("cached_grip", 16'(want.cgrip), 16'(cached_grip))
           & field_matches("cached_param", want.cparam, cached_param)
           & field_matches("cached_flag", 16'(want.cflag), 16'(cached_flag));
        if (!ok) mismatches++;
      end
    end
    if (long_hold_go && hold_count < HOLD_CYCLES) begin
      hold_count++;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("crc16_frame_receiver_status_cache_test NOT OK");
    $finish;
  end

  initial begin : stimulus
    frame_row_t    row;
    frame_report_t typed;
    logic [7:0]    phase_cmd [PHASES];
    logic [7:0]    phase_dev [PHASES];
    int            used;
    phase_cmd = '{8'h00, 8'hFF, 8'h00, STATUS_CMD_RST};
    phase_dev = '{8'hFF, 8'h00, 8'h00, VEHICLE_RST};
    phase_cmd[2] = 8'($urandom);
    phase_dev[2] = 8'($urandom);
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == FK_BAD_SYNC) begin
        // AA, bad second byte, then a 55 that must not sync
        frame_bytes = {};
        frame_bytes.push_back(SYNC_FIRST);
        frame_bytes.push_back(row.dev);
        frame_bytes.push_back(SYNC_SECOND);
      end else begin
        compose_frame(row.len, row.dev, row.cmd, 1'b0, row.fill, row.kind == FK_BAD_CRC);
      end
      typed = '{row.t_status, row.t_dev, row.t_cmd, row.len, 1'b0, 1'b0,
                8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00};
      send_frame_bytes(row.typed, typed);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_for_frames_done();
      apply_settings(phase_cmd[ph], phase_dev[ph]);
      send_idle_pct = (ph == 2) ? 0 : 18;
      recv_idle_pct = (ph == 2) ? 0 : 18;
      if (ph == 1) long_hold_go = 1'b1;
      used = 0;
      while (used < PHASE_BYTES) random_chunk(used);
      // finish any frame left open so the next settings start from the hunt
      while (rx_pos != 0) send_byte(8'h00, 1'b0, '0);
    end

    wait_for_frames_done();
    if (mismatches == 0) begin
      $display("crc16_frame_receiver_status_cache_test OK");
    end else begin
      $display("crc16_frame_receiver_status_cache_test NOT OK");
    end
    $finish;
  end

endmodule
